@@ rtl/tssb_pkg.sv @@
// Package: shared sizes, command codes and sequencer states of the sorted sample buffer.
package tssb_pkg;

   localparam int DEPTH = 64;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int KEY_W = 64;
   localparam int PAY_W = 64;
   localparam int REQ_W = 136;
   localparam int RSP_W = 264;
   localparam logic [KEY_W-1:0] SIGN_BIT = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic [CNT_W-1:0] MAX_RESET = CNT_W'(DEPTH);

   typedef enum logic [3:0] {
      CMD_INSERT        = 4'd0,
      CMD_FIND          = 4'd1,
      CMD_AT_OR_AFTER   = 4'd2,
      CMD_AFTER         = 4'd3,
      CMD_AT_OR_BEFORE  = 4'd4,
      CMD_BEFORE        = 4'd5,
      CMD_NEAREST       = 4'd6,
      CMD_REMOVE        = 4'd7,
      CMD_REMOVE_BEFORE = 4'd8,
      CMD_REMOVE_AFTER  = 4'd9
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_PROBE_RD,
      ST_PROBE_CHK,
      ST_NEAR_CHK,
      ST_MOVE,
      ST_WR_NEW,
      ST_EVICT,
      ST_FIN_SEL,
      ST_FIN_FIRST,
      ST_FIN_LAST,
      ST_FIN_OUT
   } state_type;

endpackage

@@ rtl/tssb_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered read data.
module tssb_ram #(
   parameter int WIDTH = 64,
   parameter int WORDS = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(WORDS)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(WORDS)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [WORDS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/timestamp_sorted_sample_buffer.sv @@
// Top level: sorted timestamp sample buffer with a sequencer over one key/payload memory.
module timestamp_sorted_sample_buffer (
   input  logic                       clock,
   input  logic                       reset,
   // req_tdata: cmd[3:0], key_in[67:4], payload_in[131:68], zero fill to 136
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [tssb_pkg::REQ_W-1:0] req_tdata,
   // rsp_tdata: found[0], key_out[64:1], payload_out[128:65], count_out[135:129],
   //            first_key[199:136], last_key[263:200]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [tssb_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [tssb_pkg::CNT_W-1:0] csr_data
);
   // The buffer holds up to 64 entries in ascending order of a signed
   // microsecond key, each with a 64-bit payload, in one memory with one
   // write and one registered read port. Each request transfer runs a binary
   // search (a read state and a compare state a step), a probe of one or two
   // entries, then for writes a copy loop that moves one entry a cycle, and
   // finally the states FIN_SEL, FIN_FIRST, FIN_LAST and FIN_OUT read the
   // selected entry and the first and last keys; FIN_OUT waits for the
   // response register to free up. req_tready is high only while the sequencer
   // is idle. A result waits in the response register until taken. The entry
   // limit is to be written by the user on the csr port (always ready) only
   // while the block is idle; the block does not enforce this. Reset sets
   // the limit to 64.
   import tssb_pkg::*;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [KEY_W-1:0] key_ff, key_in;      // biased key: sign bit flipped
   logic [PAY_W-1:0] pay_ff, pay_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] max_ff, max_in;
   logic [CNT_W-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [CNT_W-1:0] sel_ff, sel_in;
   logic             sel_ok_ff, sel_ok_in;
   logic [KEY_W-1:0] dp_ff, dp_in;
   // copy loop
   logic [CNT_W-1:0] mv_src_ff, mv_src_in, mv_cnt_ff, mv_cnt_in, mv_gap_ff, mv_gap_in;
   logic             mv_up_ff, mv_up_in;
   state_type        mv_next_ff, mv_next_in;
   logic             wr_pend_ff, wr_pend_in;
   logic [IDX_W-1:0] wr_addr_ff, wr_addr_in;
   logic [CNT_W-1:0] ins_ff, ins_in;
   // result capture
   logic [KEY_W-1:0] sel_key_ff, sel_key_in, first_ff, first_in;
   logic [PAY_W-1:0] sel_pay_ff, sel_pay_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // memory ports
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa, mem_ra;
   logic [KEY_W-1:0] mem_wkey, rd_key;
   logic [PAY_W-1:0] mem_wpay, rd_pay;

   logic [CNT_W:0]   mid_sum;
   logic             upper_srch, key_less, probe_in_range, probe_eq, found_w;
   logic [KEY_W-1:0] dc;
   logic [KEY_W-1:0] last_key;

   tssb_ram #(.WIDTH(KEY_W), .WORDS(DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wkey),
      .rd_addr (mem_ra),
      .rd_data (rd_key)
   );

   tssb_ram #(.WIDTH(PAY_W), .WORDS(DEPTH)) u_pay_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wpay),
      .rd_addr (mem_ra),
      .rd_data (rd_pay)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         max_ff       <= MAX_RESET;
         rsp_valid_ff <= 1'b0;
         wr_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_pend_ff   <= wr_pend_in;
      end
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      pay_ff      <= pay_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      sel_ff      <= sel_in;
      sel_ok_ff   <= sel_ok_in;
      dp_ff       <= dp_in;
      mv_src_ff   <= mv_src_in;
      mv_cnt_ff   <= mv_cnt_in;
      mv_gap_ff   <= mv_gap_in;
      mv_up_ff    <= mv_up_in;
      mv_next_ff  <= mv_next_in;
      wr_addr_ff  <= wr_addr_in;
      ins_ff      <= ins_in;
      sel_key_ff  <= sel_key_in;
      sel_pay_ff  <= sel_pay_in;
      first_ff    <= first_in;
      rsp_data_ff <= rsp_data_in;
   end

   // upper bound for after, at-or-before and remove-after; lower bound otherwise
   assign upper_srch = (cmd_ff inside {CMD_AFTER, CMD_AT_OR_BEFORE, CMD_REMOVE_AFTER});
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign key_less   = upper_srch ? (rd_key <= key_ff) : (rd_key < key_ff);
   assign probe_in_range = (lo_ff < count_ff);
   assign probe_eq   = probe_in_range && (rd_key == key_ff);
   assign dc         = rd_key - key_ff;
   assign found_w    = sel_ok_ff ||
                       (cmd_ff inside {CMD_INSERT, CMD_REMOVE, CMD_REMOVE_BEFORE,
                                       CMD_REMOVE_AFTER});
   assign last_key   = (count_ff != '0) ? (rd_key ^ SIGN_BIT) : '0;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      pay_in       = pay_ff;
      count_in     = count_ff;
      max_in       = max_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      sel_in       = sel_ff;
      sel_ok_in    = sel_ok_ff;
      dp_in        = dp_ff;
      mv_src_in    = mv_src_ff;
      mv_cnt_in    = mv_cnt_ff;
      mv_gap_in    = mv_gap_ff;
      mv_up_in     = mv_up_ff;
      mv_next_in   = mv_next_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      ins_in       = ins_ff;
      sel_key_in   = sel_key_ff;
      sel_pay_in   = sel_pay_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = wr_addr_ff;
      mem_wkey     = rd_key;
      mem_wpay     = rd_pay;
      mem_ra       = mid_ff[IDX_W-1:0];

      if (csr_valid) begin
         max_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in    = cmd_type'(req_tdata[3:0]);
               key_in    = req_tdata[67:4] ^ SIGN_BIT;
               pay_in    = req_tdata[131:68];
               lo_in     = '0;
               hi_in     = count_ff;
               sel_ok_in = 1'b0;
               state_in  = ST_SRCH_RD;
            end
         end
         ST_SRCH_RD: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_sum[CNT_W:1];
               mem_ra   = mid_sum[IDX_W:1];
               state_in = ST_SRCH_CMP;
            end else begin
               state_in = ST_PROBE_RD;
            end
         end
         ST_SRCH_CMP: begin
            if (key_less) begin
               lo_in = mid_ff + CNT_W'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = ST_SRCH_RD;
         end
         ST_PROBE_RD: begin
            // nearest looks at the entry below the bound first
            mem_ra   = (cmd_ff == CMD_NEAREST) ? IDX_W'(lo_ff - CNT_W'(1)) : lo_ff[IDX_W-1:0];
            state_in = ST_PROBE_CHK;
         end
         ST_PROBE_CHK: begin
            state_in = ST_FIN_SEL;
            case (cmd_ff)
               CMD_INSERT: begin
                  if (probe_eq) begin
                     state_in = ST_EVICT;
                  end else if (count_ff == CNT_W'(DEPTH)) begin
                     if (lo_ff == '0) begin
                        state_in = ST_EVICT;
                     end else begin
                        // drop the oldest, close the gap below the new slot
                        mv_src_in  = CNT_W'(1);
                        mv_gap_in  = CNT_W'(1);
                        mv_cnt_in  = lo_ff - CNT_W'(1);
                        mv_up_in   = 1'b0;
                        ins_in     = lo_ff - CNT_W'(1);
                        mv_next_in = ST_WR_NEW;
                        state_in   = ST_MOVE;
                     end
                  end else begin
                     mv_src_in  = count_ff - CNT_W'(1);
                     mv_gap_in  = CNT_W'(1);
                     mv_cnt_in  = count_ff - lo_ff;
                     mv_up_in   = 1'b1;
                     ins_in     = lo_ff;
                     count_in   = count_ff + CNT_W'(1);
                     mv_next_in = ST_WR_NEW;
                     state_in   = ST_MOVE;
                  end
               end
               CMD_FIND: begin
                  sel_ok_in = probe_eq;
                  sel_in    = lo_ff;
               end
               CMD_AT_OR_AFTER, CMD_AFTER: begin
                  sel_ok_in = probe_in_range;
                  sel_in    = lo_ff;
               end
               CMD_AT_OR_BEFORE, CMD_BEFORE: begin
                  sel_ok_in = (lo_ff != '0);
                  sel_in    = lo_ff - CNT_W'(1);
               end
               CMD_NEAREST: begin
                  if (count_ff != '0) begin
                     sel_ok_in = 1'b1;
                     if (!probe_in_range) begin
                        sel_in = count_ff - CNT_W'(1);
                     end else if (lo_ff == '0) begin
                        sel_in = '0;
                     end else begin
                        dp_in    = key_ff - rd_key;
                        mem_ra   = lo_ff[IDX_W-1:0];
                        state_in = ST_NEAR_CHK;
                     end
                  end
               end
               CMD_REMOVE: begin
                  if (probe_eq) begin
                     mv_src_in  = lo_ff + CNT_W'(1);
                     mv_gap_in  = CNT_W'(1);
                     mv_cnt_in  = count_ff - lo_ff - CNT_W'(1);
                     mv_up_in   = 1'b0;
                     count_in   = count_ff - CNT_W'(1);
                     mv_next_in = ST_FIN_SEL;
                     state_in   = ST_MOVE;
                  end
               end
               CMD_REMOVE_BEFORE: begin
                  // keep the greatest key below the bound
                  if (lo_ff > CNT_W'(1)) begin
                     mv_src_in  = lo_ff - CNT_W'(1);
                     mv_gap_in  = lo_ff - CNT_W'(1);
                     mv_cnt_in  = count_ff - lo_ff + CNT_W'(1);
                     mv_up_in   = 1'b0;
                     count_in   = count_ff - lo_ff + CNT_W'(1);
                     mv_next_in = ST_FIN_SEL;
                     state_in   = ST_MOVE;
                  end
               end
               CMD_REMOVE_AFTER: begin
                  if (probe_in_range) begin
                     count_in = lo_ff;
                  end
               end
               default: begin
                  sel_ok_in = 1'b0;
               end
            endcase
         end
         ST_NEAR_CHK: begin
            // ties go to the later entry
            sel_in   = (dp_ff < dc) ? (lo_ff - CNT_W'(1)) : lo_ff;
            state_in = ST_FIN_SEL;
         end
         ST_MOVE: begin
            // drain the write of the entry read last cycle
            mem_we = wr_pend_ff;
            if (mv_cnt_ff != '0) begin
               mem_ra     = mv_src_ff[IDX_W-1:0];
               wr_pend_in = 1'b1;
               wr_addr_in = mv_up_ff ? IDX_W'(mv_src_ff + CNT_W'(1))
                                     : IDX_W'(mv_src_ff - mv_gap_ff);
               mv_src_in  = mv_up_ff ? (mv_src_ff - CNT_W'(1)) : (mv_src_ff + CNT_W'(1));
               mv_cnt_in  = mv_cnt_ff - CNT_W'(1);
            end else begin
               state_in = mv_next_ff;
            end
         end
         ST_WR_NEW: begin
            mem_we   = 1'b1;
            mem_wa   = ins_ff[IDX_W-1:0];
            mem_wkey = key_ff;
            mem_wpay = pay_ff;
            state_in = ST_EVICT;
         end
         ST_EVICT: begin
            if (count_ff > max_ff) begin
               mv_src_in  = CNT_W'(1);
               mv_gap_in  = CNT_W'(1);
               mv_cnt_in  = count_ff - CNT_W'(1);
               mv_up_in   = 1'b0;
               count_in   = count_ff - CNT_W'(1);
               mv_next_in = ST_FIN_SEL;
               state_in   = ST_MOVE;
            end else begin
               state_in = ST_FIN_SEL;
            end
         end
         ST_FIN_SEL: begin
            mem_ra   = sel_ff[IDX_W-1:0];
            state_in = ST_FIN_FIRST;
         end
         ST_FIN_FIRST: begin
            sel_key_in = sel_ok_ff ? (rd_key ^ SIGN_BIT) : '0;
            sel_pay_in = sel_ok_ff ? rd_pay : '0;
            mem_ra     = '0;
            state_in   = ST_FIN_LAST;
         end
         ST_FIN_LAST: begin
            first_in = (count_ff != '0) ? (rd_key ^ SIGN_BIT) : '0;
            mem_ra   = IDX_W'(count_ff - CNT_W'(1));
            state_in = ST_FIN_OUT;
         end
         ST_FIN_OUT: begin
            // hold the read address until the response register frees up
            mem_ra = IDX_W'(count_ff - CNT_W'(1));
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {last_key, first_ff, count_ff, sel_pay_ff, sel_key_ff, found_w};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule

@@ tb/tb_timestamp_sorted_sample_buffer.sv @@
// Testbench for the sorted timestamp sample buffer: random and directed commands, checked by a scoreboard.
module tb_timestamp_sorted_sample_buffer;
   timeunit 1ns;
   timeprecision 1ps;
   import tssb_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 400;
   localparam int RANDOM_ITEMS = 1100;
   // codes 10..15 select no command; the block must answer with found low
   localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
   localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

   typedef struct packed {
      logic                    found;
      logic signed [KEY_W-1:0] key;
      logic [PAY_W-1:0]        payload;
      logic [CNT_W-1:0]        count;
      logic signed [KEY_W-1:0] first_key;
      logic signed [KEY_W-1:0] last_key;
   } answer_type;

   // Sorted table predictor plus queue of answers still owed by the block.
   class sample_table_board_type;
      logic signed [KEY_W-1:0] keys[$];
      logic [PAY_W-1:0]        payloads[$];
      int                      limit;
      answer_type              owed[$];
      int                      errors;

      function new();
         limit  = DEPTH;
         errors = 0;
      endfunction

      function int lower_pos(logic signed [KEY_W-1:0] k);
         int i;
         i = 0;
         while (i < keys.size() && keys[i] < k) i++;
         return i;
      endfunction

      function int upper_pos(logic signed [KEY_W-1:0] k);
         int i;
         i = 0;
         while (i < keys.size() && keys[i] <= k) i++;
         return i;
      endfunction

      function void drop_oldest();
         void'(keys.pop_front());
         void'(payloads.pop_front());
      endfunction

      function void add_sample(logic signed [KEY_W-1:0] k, logic [PAY_W-1:0] p);
         int  i;
         bit  dup;
         i   = lower_pos(k);
         dup = (i < keys.size() && keys[i] == k);
         // full store: a new smallest key goes in and straight out again
         if (!dup && keys.size() >= DEPTH) begin
            if (i == 0) begin
               dup = 1;
            end else begin
               drop_oldest();
               i--;
            end
         end
         if (!dup) begin
            keys.insert(i, k);
            payloads.insert(i, p);
         end
         if (keys.size() > limit) drop_oldest();
      endfunction

      // Apply one accepted command to the table and queue the answer it owes.
      function void note_request(logic [3:0] cmd, logic signed [KEY_W-1:0] k,
                                 logic [PAY_W-1:0] p);
         answer_type  a;
         int          i;
         int          sel;
         logic [63:0] d_prev;
         logic [63:0] d_next;
         sel = -1;
         a   = '0;
         case (cmd)
            CMD_INSERT: begin
               add_sample(k, p);
               a.found = 1'b1;
            end
            CMD_FIND: begin
               i = lower_pos(k);
               if (i < keys.size() && keys[i] == k) sel = i;
            end
            CMD_AT_OR_AFTER: begin
               i = lower_pos(k);
               if (i < keys.size()) sel = i;
            end
            CMD_AFTER: begin
               i = upper_pos(k);
               if (i < keys.size()) sel = i;
            end
            CMD_AT_OR_BEFORE: begin
               i = upper_pos(k);
               if (i > 0) sel = i - 1;
            end
            CMD_BEFORE: begin
               i = lower_pos(k);
               if (i > 0) sel = i - 1;
            end
            CMD_NEAREST: begin
               if (keys.size() > 0) begin
                  i = lower_pos(k);
                  if (i >= keys.size()) begin
                     sel = keys.size() - 1;
                  end else if (i == 0) begin
                     sel = 0;
                  end else begin
                     // distances are exact as unsigned; a tie goes to the later entry
                     d_prev = k - keys[i-1];
                     d_next = keys[i] - k;
                     sel = (d_prev < d_next) ? i - 1 : i;
                  end
               end
            end
            CMD_REMOVE: begin
               i = lower_pos(k);
               if (i < keys.size() && keys[i] == k) begin
                  keys.delete(i);
                  payloads.delete(i);
               end
               a.found = 1'b1;
            end
            CMD_REMOVE_BEFORE: begin
               // keep the greatest key below k, drop all older ones
               i = lower_pos(k);
               if (i > 1) repeat (i - 1) drop_oldest();
               a.found = 1'b1;
            end
            CMD_REMOVE_AFTER: begin
               i = upper_pos(k);
               while (keys.size() > i) begin
                  void'(keys.pop_back());
                  void'(payloads.pop_back());
               end
               a.found = 1'b1;
            end
            default: ;
         endcase
         if (sel >= 0) begin
            a.found   = 1'b1;
            a.key     = keys[sel];
            a.payload = payloads[sel];
         end
         a.count = CNT_W'(keys.size());
         if (keys.size() > 0) begin
            a.first_key = keys[0];
            a.last_key  = keys[keys.size()-1];
         end
         owed.insert(owed.size(), a);
      endfunction

      function void report(string what, logic [63:0] want, logic [63:0] got);
         errors++;
         if (errors <= 10)
            $display("mismatch %s: expected %h, got %h", what, want, got);
      endfunction

      function void check_response(logic [RSP_W-1:0] d);
         answer_type w;
         if (owed.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %h", d);
            return;
         end
         w = owed.pop_front();
         if (d[0] !== w.found)          report("found", 64'(w.found), 64'(d[0]));
         if (d[64:1] !== w.key)         report("key_out", w.key, d[64:1]);
         if (d[128:65] !== w.payload)   report("payload_out", w.payload, d[128:65]);
         if (d[135:129] !== w.count)    report("count_out", 64'(w.count), 64'(d[135:129]));
         if (d[199:136] !== w.first_key) report("first_key", w.first_key, d[199:136]);
         if (d[263:200] !== w.last_key)  report("last_key", w.last_key, d[263:200]);
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CNT_W-1:0]     csr_data = '0;

   sample_table_board_type board = new();
   int                   cycles = 0;
   int                   stall_left = 0;

   timestamp_sorted_sample_buffer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Watchdog: give up long after the slowest correct run would have ended.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Response side: check every transfer, stall at random (mostly short, now and then long).
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 15) begin
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 60);
   endfunction

   // Drive one request; a nonzero gap drops valid first, then valid is raised and held until the block is ready.
   task automatic send(logic [3:0] cmd, logic signed [KEY_W-1:0] k, logic [PAY_W-1:0] p,
                       int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, p, k, cmd};
      do @(posedge clock); while (!req_tready);
      board.note_request(cmd, k, p);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.owed.size() != 0) @(posedge clock);
   endtask

   // Write the entry limit once the block has gone quiet.
   task automatic write_limit(logic [CNT_W-1:0] v);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.limit = v;
   endtask

   // Mostly keys from a narrow window so searches hit; also extremes and full range.
   function logic signed [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 64'sd1_000_000 + $urandom_range(0, 300);
      if (r < 75) return -64'sd1_000_000 - $urandom_range(0, 100);
      if (r < 80) return {1'b1, 63'd0} + $urandom_range(0, 3);
      if (r < 85) return {1'b0, {63{1'b1}}} - $urandom_range(0, 3);
      return {$urandom, $urandom};
   endfunction

   function logic [3:0] pick_cmd(int insert_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < insert_pct) return CMD_INSERT;
      r = $urandom_range(0, 99);
      if (r < 3) return $urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI);
      if (r < 6) return CMD_REMOVE_BEFORE;
      if (r < 9) return CMD_REMOVE_AFTER;
      if (r < 22) return CMD_REMOVE;
      return $urandom_range(CMD_FIND, CMD_NEAREST);
   endfunction

   task automatic run_random(int n, int insert_pct);
      for (int j = 0; j < n; j++)
         send(pick_cmd(insert_pct), pick_key(), {$urandom, $urandom}, pick_gap());
   endtask

   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, 63'd0};
   localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {63{1'b1}}};

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty queries, extremes, duplicate, nearest tie, each remove, unused code.
      send(CMD_FIND,          64'sd5, '0, 0);
      send(CMD_NEAREST,       64'sd5, '0, 0);
      send(CMD_REMOVE_BEFORE, 64'sd5, '0, 0);
      send(CMD_INSERT,        KEY_MIN, {64{1'b1}}, 0);
      send(CMD_INSERT,        KEY_MAX, 64'h0, 0);
      send(CMD_INSERT,        64'sd10, 64'hA5A5_5A5A_0F0F_F0F0, 0);
      send(CMD_INSERT,        64'sd20, 64'h1234_5678_9ABC_DEF0, 0);
      send(CMD_INSERT,        64'sd10, 64'hDEAD, 0);
      send(CMD_FIND,          64'sd10, '0, 0);
      send(CMD_FIND,          64'sd11, '0, 0);
      send(CMD_AT_OR_AFTER,   64'sd10, '0, 0);
      send(CMD_AFTER,         64'sd10, '0, 0);
      send(CMD_AT_OR_BEFORE,  64'sd20, '0, 0);
      send(CMD_BEFORE,        64'sd20, '0, 0);
      send(CMD_NEAREST,       64'sd15, '0, 0);
      send(CMD_NEAREST,       KEY_MIN, '0, 0);
      send(CMD_AFTER,         KEY_MAX, '0, 0);
      send(CMD_BEFORE,        KEY_MIN, '0, 0);
      send(CMD_UNUSED_HI,     64'sd10, 64'hFFFF, 0);
      send(CMD_REMOVE,        64'sd10, '0, 0);
      send(CMD_REMOVE,        64'sd11, '0, 0);
      send(CMD_REMOVE_BEFORE, KEY_MAX, '0, 0);
      send(CMD_REMOVE_AFTER,  KEY_MIN, '0, 0);
      send(CMD_REMOVE_AFTER,  KEY_MIN, '0, 0);

      // Random phases across entry limits, extremes and the zero limit among them.
      run_random(260, 45);
      // hold off until every owed response is back, then carry on at the same limit
      wait_drained();
      run_random(60, 45);
      write_limit(CNT_W'(1));
      run_random(120, 50);
      write_limit(CNT_W'(5));
      run_random(150, 45);
      write_limit(CNT_W'(0));
      run_random(60, 50);
      write_limit(CNT_W'(127));
      run_random(250, 75);
      write_limit(CNT_W'(DEPTH));
      run_random(RANDOM_ITEMS - 900, 50);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.owed.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/tssb_pkg.sv
rtl/tssb_ram.sv
rtl/timestamp_sorted_sample_buffer.sv
tb/tb_timestamp_sorted_sample_buffer.sv
